>>> sv/lsbm_pkg.sv
// Shared types and constants of the line SSD block matcher.
// No dependencies; lsbm_sum_mem, lsbm_ctrl and line_ssd_block_match refer to it by scoped names.
package lsbm_pkg;

    // Configuration register widths, indexes and reset values.
    localparam int LEN_W      = 8;
    localparam int RAD_W      = 5;
    localparam int BS_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd2;

    localparam logic [LEN_W-1:0] RST_LINE_LENGTH   = 8'd128;
    localparam logic [RAD_W-1:0] RST_SEARCH_RADIUS = 5'd8;
    localparam logic [BS_W-1:0]  RST_BLOCK_SIZE    = 8'd16;
    localparam logic [BS_W-1:0]  MIN_BLOCK_SIZE    = 8'd4;

    // Per-shift sums saturate at the full 32-bit range.
    localparam int              SUM_W   = 32;
    localparam logic [SUM_W-1:0] SUM_MAX = 32'hFFFF_FFFF;

    // Result fields.
    localparam int MAX_BLOCKS  = 32;
    localparam int BLK_W       = 5;
    localparam int SHIFT_OUT_W = 6;
    localparam int OUT_DATA_W  = 16;

    typedef struct packed {
        logic [LEN_W-1:0] line_length;
        logic [RAD_W-1:0] shift_range;
        logic [BS_W-1:0]  blk_len;
    } t_cfg;

    typedef struct packed {
        logic [SHIFT_OUT_W-1:0] best_shift;
        logic [BLK_W-1:0]       block_number;
        logic                   is_global;
    } t_result;

endpackage

>>> sv/lsbm_line_mem.sv
// Pixel store of the matcher: current line and previous line memories.
// One write port shared by both, one registered read port each. Uses no package.
module lsbm_line_mem #(
    parameter int MAX_PIXELS = 128,
    parameter int PIXEL_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_PIXELS)-1:0] i_waddr,
    input  logic [PIXEL_BITS-1:0]         i_wcur,
    input  logic [PIXEL_BITS-1:0]         i_wprev,
    input  logic [$clog2(MAX_PIXELS)-1:0] i_cur_raddr,
    input  logic [$clog2(MAX_PIXELS)-1:0] i_prev_raddr,
    output logic [PIXEL_BITS-1:0]         o_cur,
    output logic [PIXEL_BITS-1:0]         o_prev
);

    logic [PIXEL_BITS-1:0] r_cur_mem  [MAX_PIXELS];
    logic [PIXEL_BITS-1:0] r_prev_mem [MAX_PIXELS];

    // Current line: written while a line streams in, read during matching.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_cur_mem[i_waddr] <= i_wcur;
        end
        o_cur <= r_cur_mem[i_cur_raddr];
    end

    // Previous line: read at the shifted position.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_prev_mem[i_waddr] <= i_wprev;
        end
        o_prev <= r_prev_mem[i_prev_raddr];
    end

endmodule

>>> sv/lsbm_sum_mem.sv
// Per-shift score sum memory of the matcher, one entry per shift.
// Depends on lsbm_pkg for the sum width.
module lsbm_sum_mem #(
    parameter int MAX_RADIUS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [$clog2(2*MAX_RADIUS+1)-1:0]     i_waddr,
    input  logic [lsbm_pkg::SUM_W-1:0]            i_wdata,
    input  logic [$clog2(2*MAX_RADIUS+1)-1:0]     i_raddr,
    output logic [lsbm_pkg::SUM_W-1:0]            o_rdata
);

    localparam int NUM_SHIFTS = 2 * MAX_RADIUS + 1;

    logic [lsbm_pkg::SUM_W-1:0] r_mem [NUM_SHIFTS];

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/lsbm_sq_acc.sv
// Squared-difference accumulator: one pixel pair per cycle, squared, then summed.
// Uses no package; widths follow from the module parameters.
module lsbm_sq_acc #(
    parameter int PIXEL_BITS = 12,
    parameter int SCORE_W    = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clr,
    input  logic                  i_valid,
    input  logic [PIXEL_BITS-1:0] i_cur,
    input  logic [PIXEL_BITS-1:0] i_prev,
    output logic [SCORE_W-1:0]    o_acc,
    output logic                  o_busy
);

    logic signed [PIXEL_BITS:0]       w_diff;
    logic signed [2*PIXEL_BITS+1:0]   w_sq;
    logic [2*PIXEL_BITS-1:0]          r_sq;
    logic                             r_sq_v;
    logic [SCORE_W-1:0]               r_acc;

    // The square of a difference of two samples fits in twice the sample width.
    assign w_diff = $signed({1'b0, i_cur}) - $signed({1'b0, i_prev});
    assign w_sq   = w_diff * w_diff;

    // Square stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else begin
            r_sq_v <= i_valid;
        end
        r_sq <= w_sq[2*PIXEL_BITS-1:0];
    end

    // Accumulate stage; cleared before each shift is scored.
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_sq_v) begin
            r_acc <= r_acc + SCORE_W'(r_sq);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = i_valid | r_sq_v;

endmodule

>>> sv/lsbm_ctrl.sv
// Sequencer of the matcher: line capture, per-block shift search, sum update
// and global choice. Depends on lsbm_pkg and drives the memories and accumulator.
module lsbm_ctrl #(
    parameter int MAX_PIXELS = 128,
    parameter int MAX_RADIUS = 16,
    parameter int SCORE_W    = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lsbm_pkg::t_cfg                        i_cfg,
    // Pixel input handshake.
    input  logic                                  i_in_valid,
    input  logic                                  i_in_last,
    output logic                                  o_in_ready,
    // Line memory control.
    output logic                                  o_line_we,
    output logic [$clog2(MAX_PIXELS)-1:0]         o_line_waddr,
    output logic [$clog2(MAX_PIXELS)-1:0]         o_cur_raddr,
    output logic [$clog2(MAX_PIXELS)-1:0]         o_prev_raddr,
    // Accumulator control.
    output logic                                  o_acc_clr,
    output logic                                  o_acc_valid,
    input  logic [SCORE_W-1:0]                    i_acc,
    input  logic                                  i_acc_busy,
    // Sum memory control.
    output logic                                  o_sum_we,
    output logic [$clog2(2*MAX_RADIUS+1)-1:0]     o_sum_addr,
    output logic [lsbm_pkg::SUM_W-1:0]            o_sum_wdata,
    input  logic [lsbm_pkg::SUM_W-1:0]            i_sum_rdata,
    // Result push toward the output register.
    input  logic                                  i_out_free,
    output logic                                  o_out_push,
    output lsbm_pkg::t_result                     o_out_result
);

    localparam int AW  = $clog2(MAX_PIXELS);
    localparam int LW  = $clog2(MAX_PIXELS + 1);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int PW  = $clog2(2 * MAX_PIXELS + MAX_RADIUS + 1) + 1;
    localparam int NS  = 2 * MAX_RADIUS + 1;
    localparam int SIW = $clog2(NS);
    localparam int EW  = (SCORE_W > lsbm_pkg::SUM_W ? SCORE_W : lsbm_pkg::SUM_W) + 1;

    localparam logic [3:0] ST_IDLE        = 4'd0;
    localparam logic [3:0] ST_BLK_START   = 4'd1;
    localparam logic [3:0] ST_SHIFT_CHECK = 4'd2;
    localparam logic [3:0] ST_SCAN        = 4'd3;
    localparam logic [3:0] ST_DRAIN       = 4'd4;
    localparam logic [3:0] ST_UPDATE      = 4'd5;
    localparam logic [3:0] ST_EMIT_BLK    = 4'd6;
    localparam logic [3:0] ST_GREAD       = 4'd7;
    localparam logic [3:0] ST_GCMP        = 4'd8;
    localparam logic [3:0] ST_GEMIT       = 4'd9;

    logic [3:0]                         r_state, n_state;
    logic [LW-1:0]                      r_pcnt, n_pcnt;
    logic signed [PW-1:0]               r_b, n_b;
    logic signed [PW-1:0]               r_end, n_end;
    logic signed [PW-1:0]               r_s, n_s;
    logic signed [PW-1:0]               r_x, n_x;
    logic                               r_have, n_have;
    logic [SCORE_W-1:0]                 r_bmin, n_bmin;
    logic signed [PW-1:0]               r_best, n_best;
    logic [lsbm_pkg::BLK_W-1:0]         r_nblk, n_nblk;
    logic [NS-1:0]                      r_seen, n_seen;
    logic                               r_rd_v;
    logic                               r_ghave, n_ghave;
    logic signed [PW-1:0]               r_gbest, n_gbest;
    logic [lsbm_pkg::SUM_W-1:0]         r_gmin, n_gmin;

    logic [LW-1:0]                      c_len;
    logic [RW-1:0]                      c_rad;
    logic [lsbm_pkg::BS_W-1:0]          c_bs_min;
    logic [LW-1:0]                      c_bs;
    logic signed [PW-1:0]               w_len_s;
    logic signed [PW-1:0]               w_rad_s;
    logic signed [PW-1:0]               w_bs_s;
    logic signed [PW-1:0]               w_b_next;
    logic signed [PW-1:0]               w_px;
    logic signed [PW-1:0]               w_sidx_full;
    logic [SIW-1:0]                     w_sidx;
    logic                               w_in_acc;
    logic                               w_shift_ok;
    logic [lsbm_pkg::SUM_W-1:0]         w_old_sum;
    logic [EW-1:0]                      w_sum_ext;

    // Effective configuration: line length and radius saturate at the maxima,
    // block size is at least four and at most the line.
    always_comb begin
        c_len    = (32'(i_cfg.line_length) > MAX_PIXELS) ? LW'(MAX_PIXELS)
                                                         : LW'(i_cfg.line_length);
        c_rad    = (32'(i_cfg.shift_range) > MAX_RADIUS) ? RW'(MAX_RADIUS)
                                                         : RW'(i_cfg.shift_range);
        c_bs_min = (i_cfg.blk_len < lsbm_pkg::MIN_BLOCK_SIZE) ? lsbm_pkg::MIN_BLOCK_SIZE
                                                              : i_cfg.blk_len;
        c_bs     = (32'(c_bs_min) > 32'(c_len)) ? c_len : LW'(c_bs_min);
    end

    // Position arithmetic in signed form.
    assign w_len_s     = PW'(c_len);
    assign w_rad_s     = PW'(c_rad);
    assign w_bs_s      = PW'(c_bs);
    assign w_b_next    = r_b + w_bs_s;
    assign w_px        = r_x + r_s;
    assign w_sidx_full = r_s + PW'(MAX_RADIUS);
    assign w_sidx      = w_sidx_full[SIW-1:0];
    assign w_in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign w_shift_ok  = (r_b + r_s >= 0) && (r_end + r_s <= w_len_s);

    // Saturating per-shift sum; an entry not yet touched in this line counts as zero.
    assign w_old_sum = r_seen[w_sidx] ? i_sum_rdata : '0;
    assign w_sum_ext = EW'(w_old_sum) + EW'(i_acc);

    // Memory and accumulator drive.
    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_line_we    = w_in_acc && (32'(r_pcnt) < MAX_PIXELS);
    assign o_line_waddr = r_pcnt[AW-1:0];
    assign o_cur_raddr  = r_x[AW-1:0];
    assign o_prev_raddr = w_px[AW-1:0];
    assign o_acc_clr    = (r_state == ST_SHIFT_CHECK);
    assign o_acc_valid  = r_rd_v;
    assign o_sum_addr   = w_sidx;
    assign o_sum_we     = (r_state == ST_UPDATE);
    assign o_sum_wdata  = (w_sum_ext > EW'(lsbm_pkg::SUM_MAX)) ? lsbm_pkg::SUM_MAX
                                                               : w_sum_ext[lsbm_pkg::SUM_W-1:0];

    // Result push: block results in order, then the global result.
    always_comb begin
        o_out_push   = i_out_free && ((r_state == ST_EMIT_BLK) || (r_state == ST_GEMIT));
        o_out_result = '0;
        if (r_state == ST_GEMIT) begin
            o_out_result.best_shift = r_gbest[lsbm_pkg::SHIFT_OUT_W-1:0];
            o_out_result.is_global  = 1'b1;
        end else begin
            o_out_result.best_shift   = r_best[lsbm_pkg::SHIFT_OUT_W-1:0];
            o_out_result.block_number = r_nblk;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        n_pcnt  = r_pcnt;
        n_b     = r_b;
        n_end   = r_end;
        n_s     = r_s;
        n_x     = r_x;
        n_have  = r_have;
        n_bmin  = r_bmin;
        n_best  = r_best;
        n_nblk  = r_nblk;
        n_seen  = r_seen;
        n_ghave = r_ghave;
        n_gbest = r_gbest;
        n_gmin  = r_gmin;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (32'(r_pcnt) < MAX_PIXELS) begin
                        n_pcnt = r_pcnt + 1'b1;
                    end
                    if (i_in_last) begin
                        n_pcnt  = '0;
                        n_seen  = '0;
                        n_ghave = 1'b0;
                        n_gbest = '0;
                        n_b     = '0;
                        n_nblk  = '0;
                        n_s     = -w_rad_s;
                        n_state = (c_len == '0) ? ST_GREAD : ST_BLK_START;
                    end
                end
            end
            ST_BLK_START: begin
                n_end   = (w_b_next > w_len_s) ? w_len_s : w_b_next;
                n_s     = -w_rad_s;
                n_have  = 1'b0;
                n_best  = '0;
                n_state = ST_SHIFT_CHECK;
            end
            ST_SHIFT_CHECK: begin
                if (r_s > w_rad_s) begin
                    n_state = ST_EMIT_BLK;
                end else if (w_shift_ok) begin
                    n_x     = r_b;
                    n_state = ST_SCAN;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            ST_SCAN: begin
                n_x = r_x + 1'b1;
                if (r_x == r_end - 1'b1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The sum entry is read meanwhile; its data is ready in the update cycle.
                if (!r_rd_v && !i_acc_busy) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!r_have || (i_acc < r_bmin)) begin
                    n_bmin = i_acc;
                    n_best = r_s;
                    n_have = 1'b1;
                end
                n_seen[w_sidx] = 1'b1;
                n_s            = r_s + 1'b1;
                n_state        = ST_SHIFT_CHECK;
            end
            ST_EMIT_BLK: begin
                if (i_out_free) begin
                    n_nblk = r_nblk + 1'b1;
                    n_b    = w_b_next;
                    if ((w_b_next >= w_len_s) ||
                        (32'(r_nblk) == lsbm_pkg::MAX_BLOCKS - 1)) begin
                        n_s     = -w_rad_s;
                        n_state = ST_GREAD;
                    end else begin
                        n_state = ST_BLK_START;
                    end
                end
            end
            ST_GREAD: begin
                n_state = (r_s > w_rad_s) ? ST_GEMIT : ST_GCMP;
            end
            ST_GCMP: begin
                if (r_seen[w_sidx] && (!r_ghave || (i_sum_rdata < r_gmin))) begin
                    n_gmin  = i_sum_rdata;
                    n_gbest = r_s;
                    n_ghave = 1'b1;
                end
                n_s     = r_s + 1'b1;
                n_state = ST_GREAD;
            end
            ST_GEMIT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pcnt  <= '0;
            r_rd_v  <= 1'b0;
            r_seen  <= '0;
            r_have  <= 1'b0;
            r_ghave <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pcnt  <= n_pcnt;
            r_rd_v  <= (r_state == ST_SCAN);
            r_seen  <= n_seen;
            r_have  <= n_have;
            r_ghave <= n_ghave;
        end
    end

    // Position and score registers.
    always_ff @(posedge i_clk) begin
        r_b     <= n_b;
        r_end   <= n_end;
        r_s     <= n_s;
        r_x     <= n_x;
        r_bmin  <= n_bmin;
        r_best  <= n_best;
        r_nblk  <= n_nblk;
        r_gbest <= n_gbest;
        r_gmin  <= n_gmin;
    end

endmodule

>>> sv/line_ssd_block_match.sv
// Line SSD block matcher. Pixel pairs stream in one per cycle and are stored
// until the transaction marked tlast; the block then accepts nothing until its
// last result has been handed to the output register. Matching tries each shift
// of each block in turn: a shift that leaves the line is skipped, a valid one
// runs an accumulator clear, one pixel pair per cycle from the line memories into
// the one squaring accumulator, the pipeline drain, then the sum update. Each
// block also has a setup step, the end of its shift loop and its result. The
// global choice then reads the per-shift sum memory with a read and a compare
// step per shift, then finishes and emits. Results leave per block in order, block
// number in tdata, followed by the global shift with tuser and tlast set. No clearing
// pass runs after reset.
// Depends on lsbm_pkg, lsbm_line_mem, lsbm_sum_mem, lsbm_sq_acc and lsbm_ctrl.
module line_ssd_block_match #(
    parameter int MAX_PIXELS = 128,
    parameter int MAX_RADIUS = 16,
    parameter int PIXEL_BITS = 12
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // Configuration write channel.
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [lsbm_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [lsbm_pkg::CFG_DATA_W-1:0]            i_cfg_data,
    // Pixel stream in.
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata: current_pixel, previous_pixel (lowest bits first), zero padded.
    input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]          s_axis_tdata,
    input  logic                                       s_axis_tlast,
    // Result stream out.
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // tdata: best_shift[5:0], block_number[10:6], zero padded.
    output logic [lsbm_pkg::OUT_DATA_W-1:0]            m_axis_tdata,
    // tuser: is_global.
    output logic [0:0]                                 m_axis_tuser,
    output logic                                       m_axis_tlast
);

    localparam int AW      = $clog2(MAX_PIXELS);
    localparam int SIW     = $clog2(2 * MAX_RADIUS + 1);
    localparam int SCORE_W = 2 * PIXEL_BITS + $clog2(MAX_PIXELS + 1);

    lsbm_pkg::t_cfg             r_cfg;
    lsbm_pkg::t_result          w_push_result;
    lsbm_pkg::t_result          r_out;
    logic                       r_out_valid;
    logic                       w_out_free;
    logic                       w_push;

    logic                       w_line_we;
    logic [AW-1:0]              w_line_waddr;
    logic [AW-1:0]              w_cur_raddr;
    logic [AW-1:0]              w_prev_raddr;
    logic [PIXEL_BITS-1:0]      w_cur;
    logic [PIXEL_BITS-1:0]      w_prev;
    logic                       w_acc_clr;
    logic                       w_acc_valid;
    logic [SCORE_W-1:0]         w_acc;
    logic                       w_acc_busy;
    logic                       w_sum_we;
    logic [SIW-1:0]             w_sum_addr;
    logic [lsbm_pkg::SUM_W-1:0] w_sum_wdata;
    logic [lsbm_pkg::SUM_W-1:0] w_sum_rdata;

    // Configuration registers; an index beyond the list is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_length <= lsbm_pkg::RST_LINE_LENGTH;
            r_cfg.shift_range <= lsbm_pkg::RST_SEARCH_RADIUS;
            r_cfg.blk_len     <= lsbm_pkg::RST_BLOCK_SIZE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lsbm_pkg::CFG_LINE_LENGTH: begin
                    r_cfg.line_length <= i_cfg_data;
                end
                lsbm_pkg::CFG_SEARCH_RADIUS: begin
                    r_cfg.shift_range <= i_cfg_data[lsbm_pkg::RAD_W-1:0];
                end
                lsbm_pkg::CFG_BLOCK_SIZE: begin
                    r_cfg.blk_len <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: loads when empty or when its transaction completes.
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_push) begin
            r_out <= w_push_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = lsbm_pkg::OUT_DATA_W'({r_out.block_number, r_out.best_shift});
    assign m_axis_tuser  = r_out.is_global;
    assign m_axis_tlast  = r_out.is_global;

    lsbm_line_mem #(
        .MAX_PIXELS (MAX_PIXELS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_mem (
        .i_clk        (i_clk),
        .i_we         (w_line_we),
        .i_waddr      (w_line_waddr),
        .i_wcur       (s_axis_tdata[PIXEL_BITS-1:0]),
        .i_wprev      (s_axis_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
        .i_cur_raddr  (w_cur_raddr),
        .i_prev_raddr (w_prev_raddr),
        .o_cur        (w_cur),
        .o_prev       (w_prev)
    );

    lsbm_sq_acc #(
        .PIXEL_BITS (PIXEL_BITS),
        .SCORE_W    (SCORE_W)
    ) u_sq_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_acc_clr),
        .i_valid (w_acc_valid),
        .i_cur   (w_cur),
        .i_prev  (w_prev),
        .o_acc   (w_acc),
        .o_busy  (w_acc_busy)
    );

    lsbm_sum_mem #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_sum_mem (
        .i_clk   (i_clk),
        .i_we    (w_sum_we),
        .i_waddr (w_sum_addr),
        .i_wdata (w_sum_wdata),
        .i_raddr (w_sum_addr),
        .o_rdata (w_sum_rdata)
    );

    lsbm_ctrl #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_RADIUS (MAX_RADIUS),
        .SCORE_W    (SCORE_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (s_axis_tvalid),
        .i_in_last    (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .o_line_we    (w_line_we),
        .o_line_waddr (w_line_waddr),
        .o_cur_raddr  (w_cur_raddr),
        .o_prev_raddr (w_prev_raddr),
        .o_acc_clr    (w_acc_clr),
        .o_acc_valid  (w_acc_valid),
        .i_acc        (w_acc),
        .i_acc_busy   (w_acc_busy),
        .o_sum_we     (w_sum_we),
        .o_sum_addr   (w_sum_addr),
        .o_sum_wdata  (w_sum_wdata),
        .i_sum_rdata  (w_sum_rdata),
        .i_out_free   (w_out_free),
        .o_out_push   (w_push),
        .o_out_result (w_push_result)
    );

endmodule
